>>> rtl/cdil_pkg.sv
// ----------------------------------------------------------------------------
// cdil_pkg
// Shared types and constants of the 3x3 cross dilation block: field widths,
// configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package cdil_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int DIM_MIN          = 3;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

>>> rtl/cdil_line_store.sv
// ----------------------------------------------------------------------------
// cdil_line_store
// One row of pixels: one write port and one registered read port. A read
// and a write to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module cdil_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [cdil_pkg::PIX_W-1:0] wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [cdil_pkg::PIX_W-1:0] rdata
);
    import cdil_pkg::*;

    pix_t mem [DEPTH];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cross_dilation_3x3_top.sv
// ----------------------------------------------------------------------------
// cross_dilation_3x3_top
// Grayscale dilation with a plus-shaped 3x3 element over a raster stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and returns, for every
// interior pixel, the maximum of the pixel and its up, down, left and right
// neighbours; border rows and columns give no beat, so a frame yields
// (width-2) x (height-2) beats and the last one carries tlast. A pixel is
// taken every cycle while the output side keeps up; the beat that completes
// a neighbourhood passes through the read stage and then the output
// register. Two row stores, each read once and written once per pixel
// and each with a registered read port, set that rate. frame_width and
// frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; write them
// only between beats.
// ----------------------------------------------------------------------------
module cross_dilation_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cdil_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdil_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cdil_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cdil_pkg::PIX_W-1:0]     m_tdata,   // [7:0] dilated_pixel
    output logic                           m_tlast    // frame_last
);
    import cdil_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (FRAME_WIDTH_RST < DIM_MIN) ? DIM_MIN :
                           ((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST);
    localparam int H_RST = (FRAME_HEIGHT_RST < DIM_MIN) ? DIM_MIN :
                           ((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST);

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        int t;
        t = int'(v);
        if (t < DIM_MIN)
        begin
            t = DIM_MIN;
        end
        else if (t > hi)
        begin
            t = hi;
        end
        return t;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    // configuration
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;

    // position and window
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    pix_t          prev_reg;

    // deferred last-column write
    logic          pend_valid_reg;
    logic          pend_sel_reg;
    logic [CW-1:0] pend_addr_reg;
    pix_t          pend_data_reg;

    // read stage
    logic          s1_valid_reg;
    logic          s1_res_reg;
    logic          s1_last_reg;
    logic          s1_sel_reg;
    pix_t          s1_down_reg;
    pix_t          sh0_reg;
    pix_t          sh1_reg;

    // output register
    logic          out_valid_reg;
    pix_t          out_data_reg;
    logic          out_last_reg;

    logic          acc;
    logic          s1_adv;
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic [RW:0]   r_tmp;
    logic          cur_sel;
    logic          end_row;
    logic          end_frame;
    logic          has_res;
    logic          wr_acc;
    logic [CW-1:0] c0_m1;
    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;

    logic          we_a;
    logic          we_b;
    logic [CW-1:0] waddr;
    pix_t          wdata;
    logic [CW-1:0] raddr_a;
    logic [CW-1:0] raddr_b;
    pix_t          rd_a;
    pix_t          rd_b;
    pix_t          up_pix;
    pix_t          mid_pix;
    pix_t          max_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WW'(W_RST);
            h_reg <= HW'(H_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  w_reg <= WW'(clamp_dim(cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: h_reg <= HW'(clamp_dim(cfg_data, MAX_HEIGHT));
                default:          ;
            endcase
        end
    end

    assign w_m1 = w_reg - WW'(1);
    assign h_m1 = h_reg - HW'(1);

    assign s1_adv   = s1_valid_reg && (!s1_res_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign acc      = s_tvalid && s_tready;

    // position of this pixel, after any wrap forced by a narrowed frame
    always_comb
    begin
        if (WW'(col_reg) >= w_reg)
        begin
            c0    = '0;
            r_tmp = (RW + 1)'(row_reg) + (RW + 1)'(1);
        end
        else
        begin
            c0    = col_reg;
            r_tmp = (RW + 1)'(row_reg);
        end
        if (r_tmp >= (RW + 1)'(h_reg))
        begin
            r0 = '0;
        end
        else
        begin
            r0 = r_tmp[RW-1:0];
        end
    end

    assign cur_sel   = r0[0];
    assign c0_m1     = c0 - CW'(1);
    assign end_row   = (WW'(c0) == w_m1);
    assign end_frame = (HW'(r0) == h_m1);
    assign has_res   = (r0 > RW'(1)) && (c0 > CW'(1));
    assign wr_acc    = acc && (c0 != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= acc && end_row;
            if (acc)
            begin
                prev_reg <= s_tdata;
                if (end_row)
                begin
                    col_reg <= '0;
                    row_reg <= end_frame ? '0 : r0 + RW'(1);
                end
                else
                begin
                    col_reg <= c0 + CW'(1);
                    row_reg <= r0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pend_sel_reg  <= cur_sel;
            pend_addr_reg <= c0;
            pend_data_reg <= s_tdata;
        end
    end

    // store a holds even rows, store b odd rows
    assign we_a    = (pend_valid_reg && !pend_sel_reg) || (wr_acc && !cur_sel);
    assign we_b    = (pend_valid_reg && pend_sel_reg) || (wr_acc && cur_sel);
    assign waddr   = pend_valid_reg ? pend_addr_reg : c0_m1;
    assign wdata   = pend_valid_reg ? pend_data_reg : prev_reg;
    assign raddr_a = cur_sel ? c0 : c0_m1;
    assign raddr_b = cur_sel ? c0_m1 : c0;

    cdil_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (acc),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    cdil_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (acc),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_res_reg  <= has_res;
            s1_last_reg <= end_row && end_frame;
            s1_sel_reg  <= cur_sel;
            s1_down_reg <= prev_reg;
        end
        if (s1_adv)
        begin
            sh1_reg <= sh0_reg;
            sh0_reg <= mid_pix;
        end
    end

    assign up_pix  = s1_sel_reg ? rd_b : rd_a;
    assign mid_pix = s1_sel_reg ? rd_a : rd_b;
    assign max_pix = max2(max2(max2(mid_pix, sh1_reg), max2(s1_down_reg, up_pix)), sh0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_res_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_res_reg)
        begin
            out_data_reg <= max_pix;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
